@@ rtl/adq_pkg.sv @@
// Shared types for the array deque: request modes and response status codes.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package adq_pkg;

   typedef enum logic [1:0] {
      MODE_PUSH_REAR  = 2'd0,
      MODE_POP_FRONT  = 2'd1,
      MODE_PUSH_FRONT = 2'd2,
      MODE_POP_REAR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   localparam int unsigned ElementWidth = 32;
   localparam int unsigned FillWidth    = 4;

endpackage

`default_nettype wire

@@ rtl/adq_if.sv @@
// Valid/ready channel interfaces for the array deque request and response.
// Depends on adq_pkg for the mode and status types.
`default_nettype none

interface adq_req_if;
   logic                                   valid;
   logic                                   ready;
   adq_pkg::mode_type                      mode;
   logic signed [adq_pkg::ElementWidth-1:0] element;

   modport source (output valid, output mode, output element, input ready);
   modport sink   (input valid, input mode, input element, output ready);
endinterface

interface adq_rsp_if;
   logic                                   valid;
   logic                                   ready;
   adq_pkg::status_type                    status;
   logic signed [adq_pkg::ElementWidth-1:0] popped_value;
   logic [adq_pkg::FillWidth-1:0]          fill_count;

   modport source (output valid, output status, output popped_value, output fill_count,
                   input ready);
   modport sink   (input valid, input status, input popped_value, input fill_count,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/array_deque_core.sv @@
// Array deque core: bounded double-ended queue in a linear slot memory.
// Depends on adq_pkg and the channel interfaces in adq_if.sv.
//
//   channel   direction  beat contents
//   req_bus   in         mode, element
//   rsp_bus   out        status, popped_value, fill_count
//
// A request beat updates the positions at once and issues at most one memory
// access: a write for a push, a registered read for a pop. The response appears
// in the cycle after the request, from the response register and the memory read
// register. A new request is taken whenever the response register is empty or its
// beat is taken in the same cycle; one request per cycle while rsp_bus is ready.
// Reset clears the positions and sets the deque empty; the slots need no clearing.
`default_nettype none

module array_deque_core #(
   parameter int unsigned DEPTH = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   adq_req_if.sink     req_bus,
   adq_rsp_if.source   rsp_bus
);

   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW   = (AW + 1 > adq_pkg::FillWidth) ? AW + 1 : adq_pkg::FillWidth;
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam int unsigned EW   = adq_pkg::ElementWidth;

   logic [EW-1:0] mem [DEPTH];

   logic [AW-1:0]  head_ff, head_in;
   logic [AW-1:0]  tail_ff, tail_in;
   logic           empty_ff, empty_in;
   logic           rsp_valid_ff;
   adq_pkg::status_type status_ff, status_in;
   logic [adq_pkg::FillWidth-1:0] fill_ff, fill_in;
   logic           pop_ok_ff, pop_ok_in;
   logic [EW-1:0]  rd_ff;

   logic           accept;
   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [CW-1:0]  count;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      status_in = adq_pkg::STATUS_OK;
      pop_ok_in = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = '0;
      rd_addr   = '0;
      unique case (req_bus.mode) inside
         adq_pkg::MODE_PUSH_REAR, adq_pkg::MODE_PUSH_FRONT: begin
            if (empty_ff) begin
               wr_en    = 1'b1;
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
            end else if (req_bus.mode == adq_pkg::MODE_PUSH_REAR) begin
               if (tail_ff == LAST) begin
                  status_in = adq_pkg::STATUS_OVERFLOW;
               end else begin
                  wr_en   = 1'b1;
                  tail_in = tail_ff + 1'b1;
                  wr_addr = tail_ff + 1'b1;
               end
            end else begin
               if (head_ff == '0) begin
                  status_in = adq_pkg::STATUS_OVERFLOW;
               end else begin
                  wr_en   = 1'b1;
                  head_in = head_ff - 1'b1;
                  wr_addr = head_ff - 1'b1;
               end
            end
         end
         adq_pkg::MODE_POP_FRONT, adq_pkg::MODE_POP_REAR: begin
            if (empty_ff) begin
               status_in = adq_pkg::STATUS_UNDERFLOW;
            end else begin
               rd_en     = 1'b1;
               pop_ok_in = 1'b1;
               rd_addr   = (req_bus.mode == adq_pkg::MODE_POP_FRONT) ? head_ff : tail_ff;
               if (head_ff == tail_ff) begin
                  empty_in = 1'b1;
                  head_in  = '0;
                  tail_in  = '0;
               end else if (req_bus.mode == adq_pkg::MODE_POP_FRONT) begin
                  head_in = head_ff + 1'b1;
               end else begin
                  tail_in = tail_ff - 1'b1;
               end
            end
         end
         default: begin
            status_in = adq_pkg::STATUS_OK;
         end
      endcase
      count   = empty_in ? '0 : (CW'(tail_in) - CW'(head_in) + CW'(1));
      fill_in = count[adq_pkg::FillWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         mem[wr_addr] <= req_bus.element;
      end
      if (accept && rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            empty_ff     <= empty_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         fill_ff   <= fill_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.popped_value = pop_ok_ff ? rd_ff : '0;
   assign rsp_bus.fill_count   = fill_ff;

   a_empty_home: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty deque with nonzero positions");

   a_order: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> head_ff <= tail_ff)
      else $error("head position beyond tail position");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request gave no response");

   a_no_false_underflow: assert property (@(posedge clock) disable iff (reset)
      (accept && !empty_ff) |=> status_ff != adq_pkg::STATUS_UNDERFLOW)
      else $error("underflow reported on a non-empty deque");

   a_pop_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && pop_ok_in && head_ff == tail_ff) |=> empty_ff)
      else $error("removing the last element did not empty the deque");

endmodule

`default_nettype wire

@@ bench/array_deque_core_tb.sv @@
// Self-checking bench for array_deque_core: random and directed deque requests, each
// response compared with a behavioral deque model. Needs adq_pkg and the adq_if channels.
`timescale 1ns / 100ps

module array_deque_core_tb;

   localparam int unsigned DEPTH     = 8;
   localparam int unsigned PosWidth  = $clog2(DEPTH);
   localparam int unsigned ElemBits  = adq_pkg::ElementWidth;
   localparam int unsigned FillBits  = adq_pkg::FillWidth;
   localparam int          LongHold  = 120;
   localparam int          IdleLimit = 2000;
   localparam int          RandomRequests = 750;

   typedef struct {
      adq_pkg::mode_type          mode;
      logic signed [ElemBits-1:0] element;
      bit                         drain;
   } deque_request_type;

   typedef struct {
      adq_pkg::status_type        status;
      logic signed [ElemBits-1:0] popped;
      logic [FillBits-1:0]        fill;
   } deque_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   adq_req_if req_bus ();
   adq_rsp_if rsp_bus ();

   array_deque_core #(.DEPTH(DEPTH)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // Model state of the deque.
   logic [ElemBits-1:0]     deque_store [DEPTH];
   logic [PosWidth-1:0]     front_pos = '0;
   logic [PosWidth-1:0]     rear_pos  = '0;
   bit                      vacant    = 1'b1;

   deque_request_type pending_requests [$];
   deque_answer_type  predicted_answers [$];

   int  error_count     = 0;
   int  answers_checked = 0;
   int  gap_left        = 0;
   int  calm_send       = 0;
   int  stall_left      = 0;
   int  calm_take       = 0;
   int  idle_cycles     = 0;
   bit  long_hold_done  = 1'b0;
   bit  offer;
   deque_request_type next_request;
   deque_answer_type  due;

   function automatic deque_answer_type deque_apply(adq_pkg::mode_type op,
                                                    logic signed [ElemBits-1:0] value);
      deque_answer_type ans;
      ans.status = adq_pkg::STATUS_OK;
      ans.popped = '0;
      case (op)
         adq_pkg::MODE_PUSH_REAR, adq_pkg::MODE_PUSH_FRONT: begin
            if (vacant) begin
               deque_store[0] = value;
               front_pos = '0;
               rear_pos  = '0;
               vacant    = 1'b0;
            end else if (op == adq_pkg::MODE_PUSH_REAR) begin
               if (rear_pos == DEPTH - 1) begin
                  ans.status = adq_pkg::STATUS_OVERFLOW;
               end else begin
                  rear_pos = rear_pos + 1'b1;
                  deque_store[rear_pos] = value;
               end
            end else begin
               if (front_pos == 0) begin
                  ans.status = adq_pkg::STATUS_OVERFLOW;
               end else begin
                  front_pos = front_pos - 1'b1;
                  deque_store[front_pos] = value;
               end
            end
         end
         default: begin
            if (vacant) begin
               ans.status = adq_pkg::STATUS_UNDERFLOW;
            end else begin
               ans.popped = (op == adq_pkg::MODE_POP_FRONT) ? deque_store[front_pos]
                                                            : deque_store[rear_pos];
               if (front_pos == rear_pos) begin
                  vacant    = 1'b1;
                  front_pos = '0;
                  rear_pos  = '0;
               end else if (op == adq_pkg::MODE_POP_FRONT) begin
                  front_pos = front_pos + 1'b1;
               end else begin
                  rear_pos = rear_pos - 1'b1;
               end
            end
         end
      endcase
      ans.fill = vacant ? '0 : FillBits'(int'(rear_pos) - int'(front_pos) + 1);
      return ans;
   endfunction

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   task automatic add_request(adq_pkg::mode_type op, logic signed [ElemBits-1:0] value,
                              bit drain = 1'b0);
      deque_request_type item;
      item.mode    = op;
      item.element = value;
      item.drain   = drain;
      pending_requests.push_back(item);
   endtask

   function automatic logic [ElemBits-1:0] pick_element();
      case ($urandom_range(0, 15))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int random_left;
      int phase;
      int span;
      int push_share;
      adq_pkg::mode_type op;

      req_bus.valid   = 1'b0;
      req_bus.mode    = adq_pkg::MODE_PUSH_REAR;
      req_bus.element = '0;
      rsp_bus.ready   = 1'b0;

      // Underflow on empty, overflow at both ends, extremes of the element and
      // emptying through a rear pop.
      add_request(adq_pkg::MODE_POP_FRONT, 0);
      add_request(adq_pkg::MODE_POP_REAR, 0);
      add_request(adq_pkg::MODE_PUSH_FRONT, 32'sh7FFF_FFFF);
      add_request(adq_pkg::MODE_PUSH_FRONT, 32'sh8000_0000);
      add_request(adq_pkg::MODE_PUSH_REAR, 32'sh8000_0000);
      add_request(adq_pkg::MODE_PUSH_REAR, -1);
      add_request(adq_pkg::MODE_PUSH_REAR, 0);
      add_request(adq_pkg::MODE_PUSH_REAR, 1);
      add_request(adq_pkg::MODE_PUSH_REAR, 32'sh5555_5555);
      add_request(adq_pkg::MODE_PUSH_REAR, 32'shAAAA_AAAA);
      add_request(adq_pkg::MODE_PUSH_REAR, 32'sh1234_5678);
      add_request(adq_pkg::MODE_PUSH_REAR, 32'sh0F0F_0F0F);
      add_request(adq_pkg::MODE_PUSH_FRONT, 32'shF0F0_F0F0);
      add_request(adq_pkg::MODE_POP_FRONT, 0);
      add_request(adq_pkg::MODE_POP_FRONT, 0);
      add_request(adq_pkg::MODE_PUSH_FRONT, 32'shDEAD_BEEF);
      add_request(adq_pkg::MODE_POP_REAR, 0);
      add_request(adq_pkg::MODE_POP_FRONT, 0);
      add_request(adq_pkg::MODE_POP_REAR, 0);
      add_request(adq_pkg::MODE_POP_FRONT, 0);
      add_request(adq_pkg::MODE_POP_REAR, 0);
      add_request(adq_pkg::MODE_POP_FRONT, 0);
      add_request(adq_pkg::MODE_PUSH_REAR, -1);
      add_request(adq_pkg::MODE_POP_REAR, 0);
      add_request(adq_pkg::MODE_POP_REAR, 0);
      add_request(adq_pkg::MODE_PUSH_REAR, 0, 1'b1);

      // Random phases lean toward filling, draining or neither, so that both
      // ends of the array and the empty state are visited often.
      random_left = RandomRequests;
      while (random_left > 0) begin
         phase = $urandom_range(0, 2);
         span  = $urandom_range(8, 40);
         push_share = (phase == 0) ? 80 : (phase == 1) ? 20 : 50;
         if ($urandom_range(0, 5) == 0) add_request(adq_pkg::MODE_PUSH_REAR, 0, 1'b1);
         repeat (span) begin
            if ($urandom_range(0, 99) < push_share) begin
               op = $urandom_range(0, 1) ? adq_pkg::MODE_PUSH_REAR
                                         : adq_pkg::MODE_PUSH_FRONT;
            end else begin
               op = $urandom_range(0, 1) ? adq_pkg::MODE_POP_FRONT
                                         : adq_pkg::MODE_POP_REAR;
            end
            add_request(op, pick_element());
            random_left--;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_requests.size() != 0 || req_bus.valid || predicted_answers.size() != 0) begin
         @(negedge clock);
      end
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predicted_answers.push_back(deque_apply(req_bus.mode, req_bus.element));
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0) begin
               if (pending_requests[0].drain) begin
                  if (predicted_answers.size() == 0) void'(pending_requests.pop_front());
               end else begin
                  next_request = pending_requests.pop_front();
                  req_bus.mode    <= next_request.mode;
                  req_bus.element <= next_request.element;
                  offer = 1'b1;
                  if (calm_send > 0) begin
                     calm_send--;
                  end else begin
                     gap_left = pick_idle();
                     if ($urandom_range(0, 49) == 0) calm_send = $urandom_range(20, 60);
                  end
               end
            end
            req_bus.valid <= offer;
         end
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_answers.size() == 0) begin
               $error("response beat with no request outstanding");
               error_count++;
            end else begin
               due = predicted_answers.pop_front();
               if (rsp_bus.status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_bus.status);
                  error_count++;
               end
               if (rsp_bus.popped_value !== due.popped) begin
                  $error("popped_value: expected %0d, got %0d", due.popped,
                         rsp_bus.popped_value);
                  error_count++;
               end
               if (rsp_bus.fill_count !== due.fill) begin
                  $error("fill_count: expected %0d, got %0d", due.fill, rsp_bus.fill_count);
                  error_count++;
               end
               answers_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!long_hold_done && answers_checked >= 300) begin
            long_hold_done = 1'b1;
            stall_left = LongHold - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (calm_take > 0) begin
               calm_take--;
            end else begin
               stall_left = pick_idle();
               if ($urandom_range(0, 49) == 0) calm_take = $urandom_range(20, 60);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

@@ files.f @@
rtl/adq_pkg.sv
rtl/adq_if.sv
rtl/array_deque_core.sv
bench/array_deque_core_tb.sv
